// ===== rtl/bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, constants and the character-to-glyph mapping for the
// bitmap glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int GLYPH_COUNT_DEF   = 256;
  localparam int MAX_AREA_SIDE_DEF = 1024;

  localparam int GLYPH_SIDE = 8;
  localparam int ROW_W      = 3;     // bits to count rows or columns of a glyph
  localparam int CODE_W     = 8;
  localparam int FONT_ADR_W = 11;
  localparam int ROW_BITS_W = 8;
  localparam int ORIGIN_W   = 12;
  localparam int POS_W      = 13;    // origin plus up to seven, signed
  localparam int COLOR_W    = 32;
  localparam int AREA_REG_W = 11;
  localparam int AREA_W     = 12;    // clamped side, holds MAX_AREA_SIDE up to 2048
  localparam int PIX_ADR_W  = 20;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 1'd1;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [CODE_W-1:0] LOWER_BASE = 8'd1;
  localparam logic [CODE_W-1:0] UPPER_BASE = 8'd33;
  localparam logic [CODE_W-1:0] DIGIT_BASE = 8'd62;
  localparam logic [CODE_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LO_Z  = 8'h7a;
  localparam logic [CODE_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CODE_W-1:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CODE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FLUSH
  } raster_state_t;

  // Draw item handed from the top level to the raster sequencer
  typedef struct packed {
    logic [CODE_W-1:0]          glyph;
    logic signed [ORIGIN_W-1:0] ox;
    logic signed [ORIGIN_W-1:0] oy;
    logic [COLOR_W-1:0]         fore;
    logic [COLOR_W-1:0]         back;
    logic                       fill;
  } draw_cmd_t;

  function automatic logic [CODE_W-1:0] map_glyph(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] g;
    g = c;
    priority if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      g = c - CHAR_LO_A + LOWER_BASE;
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      g = c - CHAR_UP_A + UPPER_BASE;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      g = c - CHAR_ZERO + DIGIT_BASE;
    end else begin
      g = c;
    end
    return g;
  endfunction

endpackage

// ===== rtl/bgr_ifs.sv =====
// ----------------------------------------------------------------------------
// bgr channel interfaces
// Valid/ready channels for command items in and pixel writes out.
// ----------------------------------------------------------------------------
interface bgr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [bgr_pkg::FONT_ADR_W-1:0]      font_address;
  logic [bgr_pkg::ROW_BITS_W-1:0]      font_row;
  logic [bgr_pkg::CODE_W-1:0]          char_code;
  logic signed [bgr_pkg::ORIGIN_W-1:0] origin_x;
  logic signed [bgr_pkg::ORIGIN_W-1:0] origin_y;
  logic [bgr_pkg::COLOR_W-1:0]         fore_color;
  logic [bgr_pkg::COLOR_W-1:0]         back_color;
  logic                                fill_background;

  modport source (output valid, command, font_address, font_row, char_code, origin_x,
                  origin_y, fore_color, back_color, fill_background, input ready);
  modport sink (input valid, command, font_address, font_row, char_code, origin_x,
                origin_y, fore_color, back_color, fill_background, output ready);
endinterface

interface bgr_pix_if;
  logic                            valid;
  logic                            ready;
  logic [bgr_pkg::PIX_ADR_W-1:0]   pixel_address;
  logic [bgr_pkg::COLOR_W-1:0]     pixel_value;
  logic                            last_write;

  modport source (output valid, pixel_address, pixel_value, last_write, input ready);
  modport sink (input valid, pixel_address, pixel_value, last_write, output ready);
endinterface

// ===== rtl/bgr_font_mem.sv =====
// ----------------------------------------------------------------------------
// bgr_font_mem
// Font row store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bgr_font_mem #(
  parameter int DEPTH = bgr_pkg::GLYPH_COUNT_DEF * bgr_pkg::GLYPH_SIDE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [bgr_pkg::ROW_BITS_W-1:0]  wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [bgr_pkg::ROW_BITS_W-1:0]  rdata
);

  logic [bgr_pkg::ROW_BITS_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// ===== rtl/bgr_raster.sv =====
// ----------------------------------------------------------------------------
// bgr_raster
// Walks the 8x8 cell of one draw item, one pixel a cycle unless the output
// stalls, reading one font row per glyph row, clipping, and emitting pixel
// writes through a one-deep hold stage so the final write can carry last_write.
// ----------------------------------------------------------------------------
module bgr_raster #(
  parameter int GLYPH_COUNT = bgr_pkg::GLYPH_COUNT_DEF,
  parameter int GW          = $clog2(GLYPH_COUNT),
  parameter int AW          = GW + bgr_pkg::ROW_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bgr_pkg::draw_cmd_t           cmd,
  input  logic [bgr_pkg::AREA_W-1:0]   area_w,
  input  logic [bgr_pkg::AREA_W-1:0]   area_h,
  output logic                         idle,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic [bgr_pkg::ROW_BITS_W-1:0] mem_rdata,
  bgr_pix_if.source                    pix
);

  localparam int RW = bgr_pkg::ROW_W;
  localparam int PW = bgr_pkg::POS_W;
  localparam int AWW = bgr_pkg::AREA_W;
  localparam int PAW = bgr_pkg::PIX_ADR_W;
  localparam int CW = bgr_pkg::COLOR_W;
  localparam logic [RW-1:0] LAST_IDX = RW'(bgr_pkg::GLYPH_SIDE - 1);

  bgr_pkg::raster_state_t state, state_next;

  logic [RW-1:0]             row, col;
  logic signed [PW-1:0]      x, y;
  logic signed [bgr_pkg::ORIGIN_W-1:0] ox;
  logic [PAW-1:0]            row_base;
  logic [bgr_pkg::CODE_W-1:0] glyph;
  logic                      glyph_ok;
  logic [CW-1:0]             fore, back;
  logic                      fill;

  logic                      hold_v;
  logic [PAW-1:0]            hold_addr;
  logic [CW-1:0]             hold_val;

  logic                      out_v;
  logic [PAW-1:0]            out_addr;
  logic [CW-1:0]             out_val;
  logic                      out_last;

  logic [bgr_pkg::ROW_BITS_W-1:0] row_bits;
  logic                      bit_set, in_x, in_y, qual, out_free, row_end;
  logic                      adv, take_pix, push_hold, flush_last;
  logic [PAW-1:0]            pix_addr;
  logic signed [PW+AWW-1:0]  base_prod;

  assign row_bits = glyph_ok ? mem_rdata : '0;
  assign bit_set  = row_bits[LAST_IDX - col];
  assign in_x     = !x[PW-1] && (x[PW-2:0] < area_w);
  assign in_y     = !y[PW-1] && (y[PW-2:0] < area_h);
  assign qual     = (bit_set || fill) && in_x && in_y;
  assign pix_addr = row_base + PAW'(x[PW-2:0]);
  assign out_free = !out_v || pix.ready;
  assign row_end  = (col == LAST_IDX);
  assign base_prod = (PW+AWW)'(cmd.oy) * (PW+AWW)'($signed({1'b0, area_w}));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bgr_pkg::ST_IDLE: begin
        if (start) state_next = bgr_pkg::ST_DRAW;
      end
      bgr_pkg::ST_DRAW: begin
        if (adv && row_end && row == LAST_IDX) state_next = bgr_pkg::ST_FLUSH;
      end
      bgr_pkg::ST_FLUSH: begin
        if (!hold_v || out_free) state_next = bgr_pkg::ST_IDLE;
      end
      default: state_next = bgr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    idle       = 1'b0;
    adv        = 1'b0;
    take_pix   = 1'b0;
    push_hold  = 1'b0;
    flush_last = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = {glyph[GW-1:0], row + RW'(1)};
    unique case (state)
      bgr_pkg::ST_IDLE: begin
        idle      = 1'b1;
        mem_re    = start;
        mem_raddr = {cmd.glyph[GW-1:0], RW'(0)};
      end
      bgr_pkg::ST_DRAW: begin
        // stall only when a new pixel meets an occupied hold stage and the output is full
        adv       = !(qual && hold_v) || out_free;
        take_pix  = adv && qual;
        push_hold = adv && qual && hold_v;
        mem_re    = adv && row_end && (row != LAST_IDX);
      end
      bgr_pkg::ST_FLUSH: begin
        push_hold  = hold_v && out_free;
        flush_last = push_hold;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bgr_pkg::ST_IDLE;
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      state <= state_next;
      if (take_pix) begin
        hold_v <= 1'b1;
      end else if (push_hold) begin
        hold_v <= 1'b0;
      end
      if (push_hold) begin
        out_v <= 1'b1;
      end else if (pix.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bgr_pkg::ST_IDLE && start) begin
      glyph    <= cmd.glyph;
      glyph_ok <= {1'b0, cmd.glyph} < (bgr_pkg::CODE_W + 1)'(GLYPH_COUNT);
      ox       <= cmd.ox;
      x        <= PW'(cmd.ox);
      y        <= PW'(cmd.oy);
      row_base <= base_prod[PAW-1:0];
      fore     <= cmd.fore;
      back     <= cmd.back;
      fill     <= cmd.fill;
      row      <= '0;
      col      <= '0;
    end else if (adv) begin
      col <= col + RW'(1);
      if (row_end) begin
        // next glyph row: rewind x and step the row base by one stride
        row      <= row + RW'(1);
        x        <= PW'(ox);
        y        <= y + PW'(1);
        row_base <= row_base + PAW'(area_w);
      end else begin
        x <= x + PW'(1);
      end
    end
    if (take_pix) begin
      hold_addr <= pix_addr;
      hold_val  <= bit_set ? fore : back;
    end
    if (push_hold) begin
      out_addr <= hold_addr;
      out_val  <= hold_val;
      out_last <= flush_last;
    end
  end

  assign pix.valid         = out_v;
  assign pix.pixel_address = out_addr;
  assign pix.pixel_value   = out_val;
  assign pix.last_write    = out_last;

endmodule

// ===== rtl/bitmap_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_glyph_renderer_unit
// 8x8 bitmap font character generator: font row loads and clipped glyph
// draws that emit up to one pixel write per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Load item: no result; the next item is taken at once.
// Draw item: after accept, the 64 cell positions are walked and then a flush
//   state retires the held final write; each write waits in the hold stage
//   for the next write or cell end.
// Reset clears control state and loads area 320 x 200; the font store is not
//   cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_glyph_renderer_unit #(
  parameter int GLYPH_COUNT   = bgr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_AREA_SIDE = bgr_pkg::MAX_AREA_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgr_pkg::AREA_REG_W-1:0]   cfg_data,
  bgr_cmd_if.sink                          req,
  bgr_pix_if.source                        pix
);

  localparam int DEPTH = GLYPH_COUNT * bgr_pkg::GLYPH_SIDE;
  localparam int GW    = $clog2(GLYPH_COUNT);
  localparam int AW    = GW + bgr_pkg::ROW_W;
  localparam int AWW   = bgr_pkg::AREA_W;

  logic [bgr_pkg::AREA_REG_W-1:0] area_width, area_height;
  logic [AWW-1:0]                 area_w, area_h;
  logic                           idle, accept, start, load_we;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [bgr_pkg::ROW_BITS_W-1:0] mem_rdata;
  bgr_pkg::draw_cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= bgr_pkg::AREA_REG_W'(320);
      area_height <= bgr_pkg::AREA_REG_W'(200);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bgr_pkg::REG_AREA_WIDTH:  area_width  <= cfg_data;
        bgr_pkg::REG_AREA_HEIGHT: area_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp oversized sides
  assign area_w = ({1'b0, area_width} > AWW'(MAX_AREA_SIDE)) ? AWW'(MAX_AREA_SIDE)
                                                              : {1'b0, area_width};
  assign area_h = ({1'b0, area_height} > AWW'(MAX_AREA_SIDE)) ? AWW'(MAX_AREA_SIDE)
                                                               : {1'b0, area_height};

  assign req.ready = idle;
  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.command == bgr_pkg::CMD_DRAW);
  // Drop loads beyond the store
  assign load_we   = accept && (req.command == bgr_pkg::CMD_LOAD)
                     && ({1'b0, req.font_address} < (bgr_pkg::FONT_ADR_W + 1)'(DEPTH));

  assign cmd.glyph = bgr_pkg::map_glyph(req.char_code);
  assign cmd.ox    = req.origin_x;
  assign cmd.oy    = req.origin_y;
  assign cmd.fore  = req.fore_color;
  assign cmd.back  = req.back_color;
  assign cmd.fill  = req.fill_background;

  bgr_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (req.font_address[AW-1:0]),
    .wdata (req.font_row),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bgr_raster #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GW          (GW),
    .AW          (AW)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .area_w    (area_w),
    .area_h    (area_h),
    .idle      (idle),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .pix       (pix)
  );

  // A draw item closes the input until the cell is walked and the final write is retired
  a_draw_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == bgr_pkg::CMD_DRAW |=> !req.ready)
    else $error("input ready right after a draw item");

  // A load while the output is empty never produces a pixel write
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == bgr_pkg::CMD_LOAD && !pix.valid
    |=> !pix.valid)
    else $error("pixel write after a load item");

  // Reset leaves the block idle with no pending write
  a_reset_idle: assert property (@(posedge clk)
    rst |=> req.ready && !pix.valid)
    else $error("block not idle after reset");

endmodule
